### design/layer_blend_unit_core_macros.svh
// assertion macros used by the layer blend top level file
`ifndef LAYER_BLEND_UNIT_CORE_MACROS_SVH
`define LAYER_BLEND_UNIT_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LBU_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("layer blend check failed");

// next-cycle implication
`define LBU_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("layer blend check failed");

`endif

### design/lbu_pkg.sv
// types, constants and codes of the layer blend unit
package lbu_pkg;

   localparam int CH_W = 8;
   localparam logic [CH_W-1:0] CHANNEL_MAX = 8'd255;

   // blend mode codes
   localparam logic [1:0] MODE_NORMAL   = 2'd0;
   localparam logic [1:0] MODE_ADD      = 2'd1;
   localparam logic [1:0] MODE_MULTIPLY = 2'd2;
   localparam logic [1:0] MODE_SCREEN   = 2'd3;

   // register indexes
   localparam logic REG_OPACITY = 1'b0;
   localparam logic REG_MODE    = 1'b1;

   localparam int PIPE_DEPTH = 3;

   // every blend is brought to a numerator over 255^2
   localparam logic [15:0] FULL_SCALE = 16'd65025;
   localparam logic [23:0] SCREEN_TOP = 24'd16581375;
   localparam int NUM_W  = 24;
   localparam int DIVD_W = 25;

   // round half up: floor((2n + 255^2) / (2 * 255^2)) by reciprocal
   localparam longint unsigned RECIP_DIV = 64'd130050;
   localparam int RECIP_SHIFT = 42;
   localparam int RECIP_W = 26;
   localparam logic [RECIP_W-1:0] RECIP_K =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + RECIP_DIV - 64'd1) / RECIP_DIV);
   localparam int PROD_W = DIVD_W + RECIP_W;

   typedef struct packed {
      logic            advance;
      logic [1:0]      mode;
      logic [CH_W-1:0] opacity;
   } lane_ctrl_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } merge_status_type;

endpackage

### design/lbu_lane.sv
// one colour channel of the blend: three-stage pipeline with exact rounding
module lbu_lane (
   input  logic                       clock,
   input  lbu_pkg::lane_ctrl_type     ctrl,
   input  logic [lbu_pkg::CH_W-1:0]   top_ch,
   input  logic [lbu_pkg::CH_W-1:0]   base_ch,
   output logic [lbu_pkg::CH_W-1:0]   result
);

   logic [15:0] a_o, b_no, na_no, s1_v;
   logic [16:0] add_sum;
   logic [lbu_pkg::CH_W-1:0] s1_w;
   logic s1_sub;

   logic [15:0] v_ff, v_in;
   logic [lbu_pkg::CH_W-1:0] w_ff, w_in;
   logic sub_ff, sub_in;
   logic [lbu_pkg::NUM_W-1:0] prod1_ff, prod1_in;
   logic sub2_ff, sub2_in;
   logic [lbu_pkg::NUM_W-1:0] numer;
   logic [lbu_pkg::DIVD_W-1:0] divd;
   logic [lbu_pkg::PROD_W-1:0] quot_ff, quot_in;

   // stage one: the mode-specific factor pair
   always_comb begin
      a_o     = 16'(top_ch) * 16'(ctrl.opacity);
      b_no    = 16'(base_ch) * 16'(lbu_pkg::CHANNEL_MAX - ctrl.opacity);
      na_no   = 16'(lbu_pkg::CHANNEL_MAX - top_ch) * 16'(lbu_pkg::CHANNEL_MAX - ctrl.opacity);
      add_sum = 17'(base_ch) * 17'(lbu_pkg::CHANNEL_MAX) + 17'(a_o);
      s1_v    = 16'(a_o + b_no);
      s1_w    = lbu_pkg::CHANNEL_MAX;
      s1_sub  = 1'b0;
      case (ctrl.mode)
         lbu_pkg::MODE_ADD: begin
            if (add_sum > 17'(lbu_pkg::FULL_SCALE)) begin
               s1_v = lbu_pkg::FULL_SCALE;
            end else begin
               s1_v = add_sum[15:0];
            end
         end
         lbu_pkg::MODE_MULTIPLY: begin
            s1_v = 16'(16'(top_ch) * 16'(lbu_pkg::CHANNEL_MAX) + na_no);
            s1_w = base_ch;
         end
         lbu_pkg::MODE_SCREEN: begin
            s1_v   = lbu_pkg::FULL_SCALE - a_o;
            s1_w   = ~base_ch;
            s1_sub = 1'b1;
         end
         default: begin
            s1_v = 16'(a_o + b_no);
         end
      endcase
   end

   // stage three: numerator over 255^2, then the reciprocal multiply
   always_comb begin
      if (sub2_ff) begin
         numer = lbu_pkg::SCREEN_TOP - prod1_ff;
      end else begin
         numer = prod1_ff;
      end
      divd = {numer, 1'b0} + lbu_pkg::DIVD_W'(lbu_pkg::FULL_SCALE);
   end

   always_comb begin
      v_in     = ctrl.advance ? s1_v : v_ff;
      w_in     = ctrl.advance ? s1_w : w_ff;
      sub_in   = ctrl.advance ? s1_sub : sub_ff;
      prod1_in = ctrl.advance ? lbu_pkg::NUM_W'(v_ff) * lbu_pkg::NUM_W'(w_ff) : prod1_ff;
      sub2_in  = ctrl.advance ? sub_ff : sub2_ff;
      quot_in  = ctrl.advance ?
                 lbu_pkg::PROD_W'(divd) * lbu_pkg::PROD_W'(lbu_pkg::RECIP_K) : quot_ff;
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      w_ff     <= w_in;
      sub_ff   <= sub_in;
      prod1_ff <= prod1_in;
      sub2_ff  <= sub2_in;
      quot_ff  <= quot_in;
   end

   assign result = quot_ff[lbu_pkg::RECIP_SHIFT +: lbu_pkg::CH_W];

endmodule

### design/lbu_merge.sv
// gathers the three lane results into one item, output register plus skid stage
module lbu_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [lbu_pkg::CH_W-1:0]    lane_red,
   input  logic [lbu_pkg::CH_W-1:0]    lane_green,
   input  logic [lbu_pkg::CH_W-1:0]    lane_blue,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [lbu_pkg::CH_W-1:0]    rsp_out_red,
   output logic [lbu_pkg::CH_W-1:0]    rsp_out_green,
   output logic [lbu_pkg::CH_W-1:0]    rsp_out_blue,
   output lbu_pkg::merge_status_type   status
);

   localparam int ITEM_W = 3 * lbu_pkg::CH_W;

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic [ITEM_W-1:0] out_data_ff, out_data_in;
   logic [ITEM_W-1:0] skid_data_ff, skid_data_in;
   logic [ITEM_W-1:0] lane_item;
   logic pop;

   assign lane_item = {lane_red, lane_green, lane_blue};
   assign pop       = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no push can arrive while the skid stage is full
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = lane_item;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = lane_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_red       = out_data_ff[2*lbu_pkg::CH_W +: lbu_pkg::CH_W];
   assign rsp_out_green     = out_data_ff[lbu_pkg::CH_W +: lbu_pkg::CH_W];
   assign rsp_out_blue      = out_data_ff[0 +: lbu_pkg::CH_W];
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

### design/layer_blend_unit_core.sv
// top level of the layer blend unit: registers, lanes and output stage
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  top_* and base_* channels
//   rsp_         out         rsp_valid/rsp_stall  out_red, out_green, out_blue
//   apb          in/out      psel/penable/pready  opacity at 0x0, mode at 0x4
//
// one item per clock while the skid stage is free; an accepted item passes
// through the three lane stages (factor products, scaling multiply, reciprocal
// multiply) and the output register before rsp_valid. reset clears the valid
// bits and sets opacity to 255, mode to normal. req_stall rises only while the
// skid stage holds an item, i.e. after rsp_stall has held a finished item back.
`include "layer_blend_unit_core_macros.svh"

module layer_blend_unit_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lbu_pkg::CH_W-1:0]   req_top_red,
   input  logic [lbu_pkg::CH_W-1:0]   req_top_green,
   input  logic [lbu_pkg::CH_W-1:0]   req_top_blue,
   input  logic [lbu_pkg::CH_W-1:0]   req_base_red,
   input  logic [lbu_pkg::CH_W-1:0]   req_base_green,
   input  logic [lbu_pkg::CH_W-1:0]   req_base_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lbu_pkg::CH_W-1:0]   rsp_out_red,
   output logic [lbu_pkg::CH_W-1:0]   rsp_out_green,
   output logic [lbu_pkg::CH_W-1:0]   rsp_out_blue,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [lbu_pkg::CH_W-1:0] opacity_ff, opacity_in;
   logic [1:0] mode_ff, mode_in;
   logic [lbu_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic csr_write, accept, pipe_en;
   logic [lbu_pkg::CH_W-1:0] lane_red, lane_green, lane_blue;
   lbu_pkg::lane_ctrl_type ctrl;
   lbu_pkg::merge_status_type status;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      opacity_in = opacity_ff;
      mode_in    = mode_ff;
      if (csr_write) begin
         if (paddr[2] == lbu_pkg::REG_OPACITY) begin
            opacity_in = pwdata[lbu_pkg::CH_W-1:0];
         end else begin
            mode_in = pwdata[1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == lbu_pkg::REG_MODE) begin
         prdata = {30'd0, mode_ff};
      end else begin
         prdata = {24'd0, opacity_ff};
      end
   end

   // the whole lane pipeline moves while the skid stage is free
   assign pipe_en   = ~status.skid_valid;
   assign req_stall = ~pipe_en;
   assign accept    = req_valid & ~req_stall;

   assign vld_in = pipe_en ? {vld_ff[lbu_pkg::PIPE_DEPTH-2:0], accept} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= lbu_pkg::CHANNEL_MAX;
         mode_ff    <= lbu_pkg::MODE_NORMAL;
         vld_ff     <= '0;
      end else begin
         opacity_ff <= opacity_in;
         mode_ff    <= mode_in;
         vld_ff     <= vld_in;
      end
   end

   assign ctrl.advance = pipe_en;
   assign ctrl.mode    = mode_ff;
   assign ctrl.opacity = opacity_ff;

   lbu_lane u_lane_red (
      .clock   (clock),
      .ctrl    (ctrl),
      .top_ch  (req_top_red),
      .base_ch (req_base_red),
      .result  (lane_red)
   );

   lbu_lane u_lane_green (
      .clock   (clock),
      .ctrl    (ctrl),
      .top_ch  (req_top_green),
      .base_ch (req_base_green),
      .result  (lane_green)
   );

   lbu_lane u_lane_blue (
      .clock   (clock),
      .ctrl    (ctrl),
      .top_ch  (req_top_blue),
      .base_ch (req_base_blue),
      .result  (lane_blue)
   );

   lbu_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .push          (vld_ff[lbu_pkg::PIPE_DEPTH-1] & pipe_en),
      .lane_red      (lane_red),
      .lane_green    (lane_green),
      .lane_blue     (lane_blue),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .status        (status)
   );

   // when a finished item leaves the lanes, rsp_valid is high the next cycle
   `LBU_ASSERT_NEXT(a_lane_to_out, vld_ff[lbu_pkg::PIPE_DEPTH-1] && pipe_en, rsp_valid)
   // the skid stage only fills behind a held output item
   `LBU_ASSERT_IMPL(a_skid_behind_out, status.skid_valid, status.out_valid)
   `LBU_ASSERT_IMPL(a_skid_fill_cause, $rose(status.skid_valid), $past(rsp_valid && rsp_stall))

endmodule

### dv/layer_blend_unit_core_tb.sv
// testbench for layer_blend_unit_core: directed and random blends checked against a predictor
`timescale 1ns / 1ps

module layer_blend_unit_core_tb;

   localparam int CLK_HALF = 6;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_WAIT = 16;
   localparam int DRAIN_SLACK = 12;
   localparam int RANDOM_ITEMS = 1000;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_OFF_EVERY = 230;
   localparam int MAX_REPORTS = 100;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint unsigned FULL = 255;

   typedef struct packed {
      logic [lbu_pkg::CH_W-1:0] red;
      logic [lbu_pkg::CH_W-1:0] green;
      logic [lbu_pkg::CH_W-1:0] blue;
   } colour_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [lbu_pkg::CH_W-1:0] req_top_red = '0;
   logic [lbu_pkg::CH_W-1:0] req_top_green = '0;
   logic [lbu_pkg::CH_W-1:0] req_top_blue = '0;
   logic [lbu_pkg::CH_W-1:0] req_base_red = '0;
   logic [lbu_pkg::CH_W-1:0] req_base_green = '0;
   logic [lbu_pkg::CH_W-1:0] req_base_blue = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [lbu_pkg::CH_W-1:0] rsp_out_red;
   logic [lbu_pkg::CH_W-1:0] rsp_out_green;
   logic [lbu_pkg::CH_W-1:0] rsp_out_blue;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [2:0]               paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   // predictor copy of the registers
   logic [lbu_pkg::CH_W-1:0] opacity_now = 8'd255;
   logic [1:0]               mode_now = lbu_pkg::MODE_NORMAL;

   colour_type pending_blends[$];
   int      mismatches = 0;
   int      blends_sent = 0;
   int      results_checked = 0;
   int      settings_used = 0;
   int      mode_hits[4] = '{0, 0, 0, 0};
   bit      source_eager = 1'b0;
   bit      sink_eager = 1'b0;
   longint  cycle_count = 0;

   layer_blend_unit_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_top_red   (req_top_red),
      .req_top_green (req_top_green),
      .req_top_blue  (req_top_blue),
      .req_base_red  (req_base_red),
      .req_base_green(req_base_green),
      .req_base_blue (req_base_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_blends.size());
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   // one channel, exact rational value scaled to 255 and rounded half up
   function automatic logic [lbu_pkg::CH_W-1:0] blended_channel(
         input logic [lbu_pkg::CH_W-1:0] a, input logic [lbu_pkg::CH_W-1:0] b);
      longint unsigned av, bv, ov, num, den, r;
      av = a;
      bv = b;
      ov = opacity_now;
      num = 0;
      den = 1;
      case (mode_now)
         lbu_pkg::MODE_ADD: begin
            num = FULL * bv + av * ov;
            if (num > FULL * FULL) num = FULL * FULL;
            den = FULL;
         end
         lbu_pkg::MODE_MULTIPLY: begin
            num = bv * (FULL * av + (FULL - av) * (FULL - ov));
            den = FULL * FULL;
         end
         lbu_pkg::MODE_SCREEN: begin
            num = FULL * FULL * FULL - (FULL * FULL - av * ov) * (FULL - bv);
            den = FULL * FULL;
         end
         default: begin
            num = av * ov + bv * (FULL - ov);
            den = FULL;
         end
      endcase
      r = (2 * num + den) / (2 * den);
      if (r > FULL) r = FULL;
      return r[lbu_pkg::CH_W-1:0];
   endfunction

   function automatic colour_type blend_colours(input colour_type top, input colour_type base);
      colour_type mix;
      mix.red   = blended_channel(top.red, base.red);
      mix.green = blended_channel(top.green, base.green);
      mix.blue  = blended_channel(top.blue, base.blue);
      return mix;
   endfunction

   // two-phase register access, address is index * 4
   task automatic csr_access(input logic idx, input logic write_en, input logic [31:0] value,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write_en;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_registers();
      logic [31:0] rd;
      csr_access(lbu_pkg::REG_OPACITY, 1'b0, 32'd0, rd);
      if (rd !== 32'(opacity_now)) report_mismatch("opacity readback", rd, 32'(opacity_now));
      csr_access(lbu_pkg::REG_MODE, 1'b0, 32'd0, rd);
      if (rd !== 32'(mode_now)) report_mismatch("mode readback", rd, 32'(mode_now));
   endtask

   // only called with the stream drained
   task automatic program_blend(input logic [31:0] opacity_word, input logic [31:0] mode_word);
      logic [31:0] rd;
      csr_access(lbu_pkg::REG_OPACITY, 1'b1, opacity_word, rd);
      opacity_now = opacity_word[lbu_pkg::CH_W-1:0];
      csr_access(lbu_pkg::REG_MODE, 1'b1, mode_word, rd);
      mode_now = mode_word[1:0];
      settings_used++;
      check_registers();
   endtask

   task automatic send_blend(input colour_type top, input colour_type base);
      int gap;
      gap = source_eager ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_top_red <= top.red;
      req_top_green <= top.green;
      req_top_blue <= top.blue;
      req_base_red <= base.red;
      req_base_green <= base.green;
      req_base_blue <= base.blue;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_blends.push_back(blend_colours(top, base));
      mode_hits[mode_now]++;
      blends_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   function automatic logic [lbu_pkg::CH_W-1:0] random_channel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return lbu_pkg::CH_W'($urandom);
      endcase
   endfunction

   function automatic colour_type random_colour();
      colour_type c;
      c.red = random_channel();
      c.green = random_channel();
      c.blue = random_channel();
      return c;
   endfunction

   // result side: random stall before each item, with stretches of none
   initial begin
      int hold;
      forever begin
         if ($urandom_range(0, 39) == 0) sink_eager = ~sink_eager;
         hold = sink_eager ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      colour_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_blends.size() == 0) begin
            report_mismatch("unexpected result", {8'd0, rsp_out_red, rsp_out_green,
                            rsp_out_blue}, 32'd0);
         end else begin
            want = pending_blends.pop_front();
            if (rsp_out_red !== want.red)
               report_mismatch("out_red", 32'(rsp_out_red), 32'(want.red));
            if (rsp_out_green !== want.green)
               report_mismatch("out_green", 32'(rsp_out_green), 32'(want.green));
            if (rsp_out_blue !== want.blue)
               report_mismatch("out_blue", 32'(rsp_out_blue), 32'(want.blue));
         end
         results_checked++;
      end
   end

   task automatic test_reset_state();
      opacity_now = 8'd255;
      mode_now = lbu_pkg::MODE_NORMAL;
      check_registers();
      // full opacity normal blend passes the top colour through
      send_blend('{8'd255, 8'd0, 8'd77}, '{8'd0, 8'd255, 8'd200});
      send_blend('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255});
      send_blend('{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255});
      wait_for_results();
   endtask

   task automatic test_directed_blends();
      logic [1:0] modes[4];
      modes = '{lbu_pkg::MODE_NORMAL, lbu_pkg::MODE_ADD, lbu_pkg::MODE_MULTIPLY,
                lbu_pkg::MODE_SCREEN};
      foreach (modes[i]) begin
         program_blend(32'd255, 32'(modes[i]));
         send_blend('{8'd255, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd255});
         // add saturates here
         send_blend('{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd200});
         send_blend('{8'd1, 8'd2, 8'd128}, '{8'd254, 8'd127, 8'd3});
         wait_for_results();
         program_blend(32'd0, 32'(modes[i]));
         send_blend('{8'd200, 8'd17, 8'd255}, '{8'd9, 8'd255, 8'd0});
         wait_for_results();
         program_blend(32'd128, 32'(modes[i]));
         send_blend('{8'd128, 8'd64, 8'd1}, '{8'd127, 8'd191, 8'd254});
         wait_for_results();
      end
   endtask

   // upper bits of a register write are dropped
   task automatic test_wide_register_writes();
      program_blend(32'hFFFF_FF80, 32'hFFFF_FFFE);
      send_blend('{8'd90, 8'd255, 8'd0}, '{8'd255, 8'd33, 8'd0});
      send_blend('{8'd170, 8'd85, 8'd255}, '{8'd85, 8'd170, 8'd255});
      wait_for_results();
   endtask

   task automatic test_random_blends();
      int          sent;
      logic [7:0]  op;
      logic [31:0] opacity_word, mode_word;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: op = 8'd0;
            1: op = 8'd255;
            default: op = 8'($urandom_range(0, 255));
         endcase
         opacity_word = ($urandom & 32'hFFFF_FF00) | 32'(op);
         mode_word = ($urandom & 32'hFFFF_FFFC) | 32'($urandom_range(0, 3));
         program_blend(opacity_word, mode_word);
         repeat (PHASE_ITEMS) begin
            if (sent % 50 == 0) source_eager = ($urandom_range(0, 3) == 0);
            send_blend(random_colour(), random_colour());
            sent++;
            // sender holds off until the unit has emptied
            if (sent % HOLD_OFF_EVERY == 0) wait_for_results();
         end
         wait_for_results();
      end
      source_eager = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_blends();
      test_wide_register_writes();
      test_random_blends();
      $display("%0d blends, %0d settings (normal %0d, add %0d, multiply %0d, screen %0d)",
               blends_sent, settings_used, mode_hits[0], mode_hits[1], mode_hits[2],
               mode_hits[3]);
      $display("%0d results checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
